### rtl/nrs_pkg.sv
`timescale 1ns / 1ps
package nrs_pkg;

    localparam int RATE_W        = 10;
    localparam int DEF_MAX_RATES = 16;

    typedef logic [RATE_W-1:0] t_rate;

    // running lower/upper neighbor state of one query
    typedef struct packed {
        logic  exact;
        logic  have_lo;
        t_rate lo;
        logic  have_hi;
        t_rate hi;
    } t_track;

    // pick the nearer neighbor, a tie goes to the higher one
    function automatic t_rate pick_nearest(input t_track trk, input t_rate req);
        t_rate res;
        res = '0;
        if (trk.exact) begin
            res = req;
        end else if (!trk.have_lo) begin
            res = trk.hi;
        end else if (!trk.have_hi) begin
            res = trk.lo;
        end else if ((req - trk.lo) < (trk.hi - req)) begin
            res = trk.lo;
        end else begin
            res = trk.hi;
        end
        return res;
    endfunction

endpackage

### rtl/nrs_table.sv
`timescale 1ns / 1ps
module nrs_table #(
    parameter int DEPTH = nrs_pkg::DEF_MAX_RATES,
    parameter int IDX_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  nrs_pkg::t_rate    i_wr_data,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output nrs_pkg::t_rate    o_rd_data
);

    nrs_pkg::t_rate r_mem [DEPTH];
    nrs_pkg::t_rate r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/nrs_track.sv
`timescale 1ns / 1ps
module nrs_track (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_en,
    input  nrs_pkg::t_rate  i_value,
    input  nrs_pkg::t_rate  i_req,
    output nrs_pkg::t_track o_track
);

    nrs_pkg::t_track r_trk;
    nrs_pkg::t_track n_trk;

    // one stored entry against the request per cycle while i_en is high
    always_comb begin
        n_trk = r_trk;
        if (i_clear) begin
            n_trk = '0;
        end else if (i_en) begin
            if (i_value == i_req) begin
                n_trk.exact = 1'b1;
            end else if (i_value < i_req) begin
                if (!r_trk.have_lo || (i_value > r_trk.lo)) begin
                    n_trk.lo      = i_value;
                    n_trk.have_lo = 1'b1;
                end
            end else begin
                if (!r_trk.have_hi || (i_value < r_trk.hi)) begin
                    n_trk.hi      = i_value;
                    n_trk.have_hi = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trk <= '0;
        end else begin
            r_trk <= n_trk;
        end
    end

    assign o_track = r_trk;

endmodule

### rtl/nearest_rate_search.sv
`timescale 1ns / 1ps
// Nearest rate search: an add transfer (i_mode = 0) stores i_rate_value in
// the next free table slot and gives no result; once MAX_RATES values are
// held further adds are dropped. A query transfer (i_mode = 1) gives one
// result: the stored value nearest to i_rate_value, a tie going to the
// higher value, with o_found = 0 and o_nearest_rate = 0 on an empty table.
// A query reads the table memory one entry per cycle through its single
// read port, and each entry goes through one shared compare unit; the read
// data is registered, and the result is then loaded into the output register.
// On an empty table a query skips the scan. A query also waits at its last
// step for as long as the output register still holds a result that has not
// been taken. o_stall is high while a query runs; a finished result waits in
// the output register, so a new transfer is taken while the result is still
// held.
module nearest_rate_search #(
    parameter int MAX_RATES = nrs_pkg::DEF_MAX_RATES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_mode,
    input  logic [nrs_pkg::RATE_W-1:0] i_rate_value,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [nrs_pkg::RATE_W-1:0] o_nearest_rate,
    output logic                       o_found
);

    // count holds 0..MAX_RATES, index addresses 0..MAX_RATES-1
    localparam int CNT_W = $clog2(MAX_RATES + 1);
    localparam int IDX_W = (MAX_RATES > 1) ? $clog2(MAX_RATES) : 1;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_rd_vld;
    nrs_pkg::t_rate   r_req;

    logic             r_out_valid;
    nrs_pkg::t_rate   r_out_rate;
    logic             r_out_found;

    logic             in_xfer;
    logic             out_xfer;
    logic             add_ok;
    logic             query_go;
    logic             out_load;
    logic             last_issue;
    nrs_pkg::t_rate   rd_data;
    nrs_pkg::t_track  trk;

    // transfers on both channels
    assign o_stall  = (r_state != ST_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;

    // an add is stored only while the table has room
    assign add_ok   = in_xfer && !i_mode && (r_count < CNT_W'(MAX_RATES));
    assign query_go = in_xfer && i_mode;

    // the last stored entry is being read this cycle
    assign last_issue = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // result moves to the output register once that register is free
    assign out_load = (r_state == ST_FIN) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (query_go) begin
                    n_idx   = '0;
                    // empty table: nothing to scan
                    n_state = (r_count == '0) ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_idx = r_idx + IDX_W'(1);
                if (last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last entry reaches the compare unit
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            // read data arrives in the cycle after its address
            r_rd_vld <= (r_state == ST_SCAN);
            if (add_ok) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (query_go) begin
            r_req <= i_rate_value;
        end
        if (out_load) begin
            r_out_found <= (r_count != '0);
            r_out_rate  <= (r_count != '0) ? nrs_pkg::pick_nearest(trk, r_req) : '0;
        end
    end

    // rate storage, one write and one registered read per cycle
    nrs_table #(
        .DEPTH (MAX_RATES),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (add_ok),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (i_rate_value),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    // shared compare unit, tracks exact hit and both neighbors
    nrs_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (query_go),
        .i_en    (r_rd_vld),
        .i_value (rd_data),
        .i_req   (r_req),
        .o_track (trk)
    );

    assign o_valid        = r_out_valid;
    assign o_nearest_rate = r_out_rate;
    assign o_found        = r_out_found;

    // fill count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RATES))
        else $error("entry count beyond table depth");

    // a stored add bumps the count by exactly one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        add_ok |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("entry count did not advance on add");

    // the scan only reads written entries
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CNT_W'(r_idx) < r_count))
        else $error("scan index beyond written entries");

    // a miss result carries a zero rate
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_rate == '0))
        else $error("miss result with nonzero rate");

    // compare unit is idle outside a scan
    a_rd_vld_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ((r_state == ST_SCAN) || (r_state == ST_DRAIN)))
        else $error("read data valid outside scan");

endmodule
